FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the pulse encoder.
// Depends on nothing; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

FILE: rtl/trcpe_pkg.sv
// Types and constants of the tri-state remote code pulse encoder.
// Depends on nothing; used by tristate_remote_code_pulse_encoder.
package trcpe_pkg;

  localparam int WORD_W      = 24;
  localparam int WORD_SYMS   = 12;
  localparam int TIME_W      = 16;
  localparam int REG_COUNT   = 7;
  localparam int CFG_ADDR_W  = 3;

  typedef logic [TIME_W-1:0] time_val_t;
  typedef logic [1:0]        sym_t;

  // Register indexes on the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SHORT_HIGH      = 3'd0,
    REG_LONG_HIGH       = 3'd1,
    REG_ZERO_LOW        = 3'd2,
    REG_ONE_LOW         = 3'd3,
    REG_FLOAT_SHORT_LOW = 3'd4,
    REG_FLOAT_LONG_LOW  = 3'd5,
    REG_SYNC_LOW        = 3'd6
  } reg_idx_t;

  // Symbol codes; the two remaining codes are sent as floating
  localparam sym_t SYM_ZERO = 2'd0;
  localparam sym_t SYM_ONE  = 2'd1;

  // Register values after reset
  localparam time_val_t RST_SHORT_HIGH      = 16'd250;
  localparam time_val_t RST_LONG_HIGH       = 16'd810;
  localparam time_val_t RST_ZERO_LOW        = 16'd690;
  localparam time_val_t RST_ONE_LOW         = 16'd210;
  localparam time_val_t RST_FLOAT_SHORT_LOW = 16'd700;
  localparam time_val_t RST_FLOAT_LONG_LOW  = 16'd200;
  localparam time_val_t RST_SYNC_LOW        = 16'd7000;

  typedef struct packed {
    time_val_t short_high;
    time_val_t long_high;
    time_val_t zero_low;
    time_val_t one_low;
    time_val_t float_short_low;
    time_val_t float_long_low;
    time_val_t sync_low;
  } timing_t;

  localparam timing_t TIMING_RST = '{
    short_high:      RST_SHORT_HIGH,
    long_high:       RST_LONG_HIGH,
    zero_low:        RST_ZERO_LOW,
    one_low:         RST_ONE_LOW,
    float_short_low: RST_FLOAT_SHORT_LOW,
    float_long_low:  RST_FLOAT_LONG_LOW,
    sync_low:        RST_SYNC_LOW
  };

endpackage

FILE: rtl/tristate_remote_code_pulse_encoder.sv
// Tri-state remote code pulse encoder: turns one code word into a pulse run.
// Depends on trcpe_pkg and assert_macros.svh.
// A taken word is held in word_r; each of its pulses passes through the output register.
// Throughput: 2*min(SYMBOL_COUNT,12)+1 pulses per word (25 by default), one per
// cycle unless out_tready stalls; the pulse counter sets it, the next word is taken
// in the cycle the sync pulse enters the output register, so words follow gap-free.
// Reset (rst_n, synchronous): timing registers take their defaults, run drops.
`include "assert_macros.svh"

module tristate_remote_code_pulse_encoder #(
  parameter int SYMBOL_COUNT = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [trcpe_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [trcpe_pkg::TIME_W-1:0]     cfg_wdata,
  // input item channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] code_word
  // pulse item channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] high_time, [31:16] low_time
  output logic        out_tlast   // last_pulse
);

  localparam int SYM_N    = (SYMBOL_COUNT > trcpe_pkg::WORD_SYMS) ?
                            trcpe_pkg::WORD_SYMS : SYMBOL_COUNT;
  localparam int LAST_IDX = 2 * SYM_N;
  localparam int CNT_W    = $clog2(LAST_IDX + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LAST_IDX);

  trcpe_pkg::timing_t tim_r;
  logic [trcpe_pkg::WORD_W-1:0] word_r;
  logic [CNT_W-1:0] cnt_r;
  logic busy_r;
  logic out_valid_r;
  trcpe_pkg::time_val_t high_r, low_r;
  logic last_r;

  logic load, at_last, in_acc;
  trcpe_pkg::time_val_t high_nxt, low_nxt;
  trcpe_pkg::sym_t sym;

  // Hold timing registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tim_r <= trcpe_pkg::TIMING_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        trcpe_pkg::REG_SHORT_HIGH:      tim_r.short_high      <= cfg_wdata;
        trcpe_pkg::REG_LONG_HIGH:       tim_r.long_high       <= cfg_wdata;
        trcpe_pkg::REG_ZERO_LOW:        tim_r.zero_low        <= cfg_wdata;
        trcpe_pkg::REG_ONE_LOW:         tim_r.one_low         <= cfg_wdata;
        trcpe_pkg::REG_FLOAT_SHORT_LOW: tim_r.float_short_low <= cfg_wdata;
        trcpe_pkg::REG_FLOAT_LONG_LOW:  tim_r.float_long_low  <= cfg_wdata;
        trcpe_pkg::REG_SYNC_LOW:        tim_r.sync_low        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: load a pulse when the output register is free or draining
  assign load      = busy_r && (!out_valid_r || out_tready);
  assign at_last   = (cnt_r == CNT_LAST);
  assign in_tready = !busy_r || (load && at_last);
  assign in_acc    = in_tvalid && in_tready;

  // Pick the pulse for the current symbol and half
  assign sym = word_r[1:0];
  always_comb begin
    high_nxt = tim_r.short_high;
    low_nxt  = tim_r.sync_low;
    if (!at_last) begin
      case (sym)
        trcpe_pkg::SYM_ZERO: begin
          high_nxt = tim_r.short_high;
          low_nxt  = tim_r.zero_low;
        end
        trcpe_pkg::SYM_ONE: begin
          high_nxt = tim_r.long_high;
          low_nxt  = tim_r.one_low;
        end
        default: begin
          // floating: short pulse first, long pulse second
          if (cnt_r[0]) begin
            high_nxt = tim_r.long_high;
            low_nxt  = tim_r.float_long_low;
          end else begin
            high_nxt = tim_r.short_high;
            low_nxt  = tim_r.float_short_low;
          end
        end
      endcase
    end
  end

  // Advance through the run; a new word may enter as the sync pulse leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (load) begin
        if (at_last) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r[0]) begin
            word_r <= word_r >> 2;
          end
        end
      end
      if (in_acc) begin
        word_r <= in_tdata;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      high_r <= high_nxt;
      low_r  <= low_nxt;
      last_r <= at_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {low_r, high_r};
  assign out_tlast  = last_r;

  // A taken word starts a run
  `ASSERT_HOLDS(a_acc_busy, clk, rst_n, in_acc |=> (busy_r && cnt_r == '0))
  // Sync leaving with no new word ends the run
  `ASSERT_HOLDS(a_end_idle, clk, rst_n, (load && at_last && !in_acc) |=> !busy_r)
  // No word is taken in the middle of a run
  `ASSERT_NEVER(a_no_mid_take, clk, rst_n, busy_r && !(load && at_last) && in_tready)
  // The counter never runs past the sync pulse
  `ASSERT_NEVER(a_cnt_range, clk, rst_n, busy_r && (cnt_r > CNT_LAST))

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Testbench for tristate_remote_code_pulse_encoder: streams code words under several
// timing settings, predicts each pulse run and checks every pulse item field by field.
// Depends on trcpe_pkg and the encoder RTL.
module tb;

  localparam int SYMBOL_COUNT  = 12;
  localparam int RANDOM_WORDS  = 460;
  localparam int RANDOM_PHASES = 4;
  localparam int IDLE_PCT      = 7;
  localparam int DRAIN_CYCLES  = 30;
  localparam int MAX_REPORTS   = 10;
  // no register sits at this index, so a write there must change nothing
  localparam logic [trcpe_pkg::CFG_ADDR_W-1:0] CFG_ADDR_UNUSED = 3'd7;

  typedef struct packed {
    logic                 last;
    trcpe_pkg::time_val_t low;
    trcpe_pkg::time_val_t high;
  } pulse_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             cfg_we     = 1'b0;
  logic [trcpe_pkg::CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [trcpe_pkg::TIME_W-1:0]     cfg_wdata  = '0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [trcpe_pkg::WORD_W-1:0]     in_tdata   = '0;  // [23:0] code_word
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [31:0]                      out_tdata;  // [15:0] high_time, [31:16] low_time
  logic                             out_tlast;  // last_pulse

  trcpe_pkg::timing_t timing_regs = trcpe_pkg::TIMING_RST;
  pulse_t  expected_pulses [$];
  bit      no_gaps     = 1'b0;
  int      mismatches  = 0;

  tristate_remote_code_pulse_encoder #(
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  // Queue one expected pulse
  function automatic void add_pulse(input trcpe_pkg::time_val_t hi,
                                    input trcpe_pkg::time_val_t lo,
                                    input logic is_sync);
    pulse_t p;
    p.high = hi;
    p.low  = lo;
    p.last = is_sync;
    expected_pulses.push_back(p);
  endfunction

  // Expand one code word into its pulse run, symbol 0 first, sync last
  function automatic void encode_word(input logic [trcpe_pkg::WORD_W-1:0] code);
    int              n_syms;
    trcpe_pkg::sym_t sym;
    n_syms = (SYMBOL_COUNT > trcpe_pkg::WORD_SYMS) ? trcpe_pkg::WORD_SYMS : SYMBOL_COUNT;
    for (int s = 0; s < n_syms; s++) begin
      sym = code[2*s +: 2];
      case (sym)
        trcpe_pkg::SYM_ZERO: begin
          add_pulse(timing_regs.short_high, timing_regs.zero_low, 1'b0);
          add_pulse(timing_regs.short_high, timing_regs.zero_low, 1'b0);
        end
        trcpe_pkg::SYM_ONE: begin
          add_pulse(timing_regs.long_high, timing_regs.one_low, 1'b0);
          add_pulse(timing_regs.long_high, timing_regs.one_low, 1'b0);
        end
        default: begin
          // both remaining codes are floating
          add_pulse(timing_regs.short_high, timing_regs.float_short_low, 1'b0);
          add_pulse(timing_regs.long_high, timing_regs.float_long_low, 1'b0);
        end
      endcase
    end
    add_pulse(timing_regs.short_high, timing_regs.sync_low, 1'b1);
  endfunction

  // Check each accepted pulse against the oldest expectation, then expand new words
  always @(posedge clk) begin : pulse_monitor
    pulse_t got;
    pulse_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.high = out_tdata[15:0];
      got.low  = out_tdata[31:16];
      got.last = out_tlast;
      if (expected_pulses.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected pulse: high %0d low %0d last %b",
                   got.high, got.low, got.last);
      end else begin
        want = expected_pulses.pop_front();
        if (got.high !== want.high || got.low !== want.low ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("pulse mismatch: expected high %0d low %0d last %b, %s",
                     want.high, want.low, want.last,
                     $sformatf("got high %0d low %0d last %b",
                               got.high, got.low, got.last));
        end
      end
    end
    if (rst_n && in_tvalid && in_tready)
      encode_word(in_tdata);
  end

  // Stall the pulse side at random unless a gap-free stretch is running
  always @(posedge clk)
    out_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);

  // Offer one code word and hold it until taken; valid stays up for the next call
  task automatic send_word(input logic [trcpe_pkg::WORD_W-1:0] code);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and hold off until every expected pulse has arrived
  task automatic drain_pulses();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_pulses.size() != 0) @(posedge clk);
  endtask

  // One register write; the enable is left up for a following write
  task automatic write_reg(input logic [trcpe_pkg::CFG_ADDR_W-1:0] idx,
                           input trcpe_pkg::time_val_t data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Write all timing registers, then poke the unused index with junk
  task automatic load_timing(input trcpe_pkg::timing_t t);
    write_reg(trcpe_pkg::REG_SHORT_HIGH,      t.short_high);
    write_reg(trcpe_pkg::REG_LONG_HIGH,       t.long_high);
    write_reg(trcpe_pkg::REG_ZERO_LOW,        t.zero_low);
    write_reg(trcpe_pkg::REG_ONE_LOW,         t.one_low);
    write_reg(trcpe_pkg::REG_FLOAT_SHORT_LOW, t.float_short_low);
    write_reg(trcpe_pkg::REG_FLOAT_LONG_LOW,  t.float_long_low);
    write_reg(trcpe_pkg::REG_SYNC_LOW,        t.sync_low);
    write_reg(CFG_ADDR_UNUSED,                trcpe_pkg::TIME_W'($urandom));
    cfg_we <= 1'b0;
    timing_regs = t;
  endtask

  function automatic trcpe_pkg::timing_t random_timing();
    trcpe_pkg::timing_t t;
    t.short_high      = trcpe_pkg::TIME_W'($urandom);
    t.long_high       = trcpe_pkg::TIME_W'($urandom);
    t.zero_low        = trcpe_pkg::TIME_W'($urandom);
    t.one_low         = trcpe_pkg::TIME_W'($urandom);
    t.float_short_low = trcpe_pkg::TIME_W'($urandom);
    t.float_long_low  = trcpe_pkg::TIME_W'($urandom);
    t.sync_low        = trcpe_pkg::TIME_W'($urandom);
    return t;
  endfunction

  // Mostly random words; a quarter are dominated by one repeated symbol code
  function automatic logic [trcpe_pkg::WORD_W-1:0] random_word();
    logic [trcpe_pkg::WORD_W-1:0] w;
    trcpe_pkg::sym_t              fill;
    w = trcpe_pkg::WORD_W'($urandom);
    if ($urandom_range(3) == 0) begin
      fill = trcpe_pkg::sym_t'($urandom);
      for (int s = 0; s < trcpe_pkg::WORD_SYMS; s++)
        if ($urandom_range(3) != 0) w[2*s +: 2] = fill;
    end
    return w;
  endfunction

  // Every symbol code, word extremes and mixed patterns at the reset timing
  task automatic test_reset_timing();
    send_word(24'h000000);
    send_word(24'h555555);
    send_word(24'hAAAAAA);
    send_word(24'hFFFFFF);
    send_word(24'hE4E4E4);
    send_word(24'h1B1B1B);
    send_word(24'h000001);
    send_word(24'h800000);
    drain_pulses();
  endtask

  // Registers at zero, at full scale and at distinct values to catch swaps
  task automatic test_timing_extremes();
    trcpe_pkg::timing_t distinct;
    distinct = '{16'h0001, 16'h8002, 16'h0004, 16'h4008, 16'h0010, 16'h2020, 16'hFFFE};
    load_timing('0);
    send_word(24'hE4E4E4);
    send_word(24'hFFFFFF);
    send_word(24'h000000);
    send_word(24'h1B1B1B);
    drain_pulses();
    load_timing('1);
    send_word(24'hE4E4E4);
    send_word(24'h555555);
    send_word(24'hAAAAAA);
    send_word(24'h1B1B1B);
    drain_pulses();
    load_timing(distinct);
    send_word(24'hE4E4E4);
    send_word(24'h1B1B1B);
    send_word(24'h5A5A5A);
    send_word(24'hA5A5A5);
    drain_pulses();
  endtask

  // Random words; random timing, reset timing last; one phase gap-free, each has a pause
  task automatic test_random_words();
    int per_phase;
    int pause_at;
    per_phase = RANDOM_WORDS / RANDOM_PHASES;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_timing(ph == RANDOM_PHASES - 1 ? trcpe_pkg::TIMING_RST : random_timing());
      no_gaps  = (ph == 2);
      pause_at = $urandom_range(per_phase - 1);
      for (int n = 0; n < per_phase; n++) begin
        if (n == pause_at)
          drain_pulses();
        send_word(random_word());
      end
      drain_pulses();
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_timing();
    test_timing_extremes();
    test_random_words();
    drain_pulses();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_pulses.size() == 0) begin
      $display("tristate_remote_code_pulse_encoder test passed");
    end else begin
      $display("tristate_remote_code_pulse_encoder test failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin
    #2_000_000;
    $display("tristate_remote_code_pulse_encoder test failed");
    $finish;
  end

endmodule
